[rtl/core/cpvr_pkg.sv]
// Shared constants and codes for the credit prefetch vertex reader.
package cpvr_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int ADDR_W   = 48;
    localparam int WORD_W   = 64;
    localparam int ROW_W    = 32;
    localparam int LBYTES_W = 9;
    localparam int WPL_W    = 6;
    localparam int LINES_W  = 16;
    localparam int PASSES_W = 11;
    localparam int PCNT_W   = 10;
    localparam int CRED_W   = 16;
    localparam int CMD_W    = 3;
    localparam int ERR_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RECEIVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORDS_PER_LINE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LINES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PASSES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_FIRST      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LAST       = 3'd6;

    localparam logic [ADDR_W-1:0]   RST_BASE_ADDRESS   = '0;
    localparam logic [LBYTES_W-1:0] RST_LINE_BYTES     = 9'd64;
    localparam logic [WPL_W-1:0]    RST_WORDS_PER_LINE = 6'd8;
    localparam logic [LINES_W-1:0]  RST_TOTAL_LINES    = '0;
    localparam logic [PASSES_W-1:0] RST_TOTAL_PASSES   = 11'd1;
    localparam logic [ROW_W-1:0]    RST_ROW_FIRST      = '0;
    localparam logic [ROW_W-1:0]    RST_ROW_LAST       = '0;

    localparam logic [CRED_W-1:0] CREDIT_MAX = 16'hFFFF;
    localparam logic [PCNT_W-1:0] PASS_MAX   = 10'd1023;

endpackage

[rtl/core/credit_prefetch_vertex_reader.sv]
// Credit-based line prefetcher with a word queue: top level.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_command, i_data_word, i_first_of_line
//  out     | output    | o_out_valid / i_out_stall | o_read_valid .. o_error (11 fields)
//  cfg     | input     | i_cfg_we                  | i_cfg_addr, i_cfg_wdata
//
// One beat in per cycle while o_in_stall is low; its result beat is shown in the cycle after
// acceptance, in step with the word queue RAM's registered read port.
// The result register stalls the input only while it holds a beat that is stalled.
// Reset is synchronous; the word queue RAM is not cleared, so there is no
// clearing pass and the block takes beats right after reset.
module credit_prefetch_vertex_reader #(
    parameter int QUEUE_DEPTH = cpvr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_we,
    input  logic [cpvr_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [cpvr_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [cpvr_pkg::CMD_W-1:0]       i_command,
    input  logic [cpvr_pkg::WORD_W-1:0]      i_data_word,
    input  logic                             i_first_of_line,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_read_valid,
    output logic [cpvr_pkg::ADDR_W-1:0]      o_read_address,
    output logic                             o_data_valid,
    output logic [cpvr_pkg::WORD_W-1:0]      o_data_word_out,
    output logic [cpvr_pkg::ROW_W-1:0]       o_row_index,
    output logic                             o_request_needed,
    output logic                             o_queue_empty,
    output logic                             o_all_lines_requested,
    output logic                             o_end_request,
    output logic                             o_end_operation,
    output logic [cpvr_pkg::ERR_W-1:0]       o_error
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int CSUM_W = cpvr_pkg::CRED_W + 1;

    // configuration
    logic [cpvr_pkg::ADDR_W-1:0]   r_base_address;
    logic [cpvr_pkg::LBYTES_W-1:0] r_line_bytes;
    logic [cpvr_pkg::WPL_W-1:0]    r_words_per_line;
    logic [cpvr_pkg::LINES_W-1:0]  r_total_lines;
    logic [cpvr_pkg::PASSES_W-1:0] r_total_passes;
    logic [cpvr_pkg::ROW_W-1:0]    r_row_first;
    logic [cpvr_pkg::ROW_W-1:0]    r_row_last;

    // working state
    logic [PTR_W-1:0]              r_head,        n_head;
    logic [CNT_W-1:0]              r_count,       n_count;
    logic [cpvr_pkg::CRED_W-1:0]   r_credits,     n_credits;
    logic [cpvr_pkg::LINES_W-1:0]  r_lines,       n_lines;
    logic [cpvr_pkg::ADDR_W-1:0]   r_next_addr,   n_next_addr;
    logic [cpvr_pkg::ROW_W-1:0]    r_cur_row,     n_cur_row;
    logic [cpvr_pkg::PCNT_W-1:0]   r_pass_count,  n_pass_count;
    logic                          r_need,        n_need;
    logic                          r_empty,       n_empty;

    // result register
    logic                          r_out_valid;
    logic                          r_read_valid,  n_read_valid;
    logic [cpvr_pkg::ADDR_W-1:0]   r_read_addr,   n_read_addr;
    logic                          r_data_valid,  n_data_valid;
    logic [cpvr_pkg::ROW_W-1:0]    r_row_index,   n_row_index;
    logic [cpvr_pkg::ERR_W-1:0]    r_error,       n_error;
    logic                          r_lines_done,  n_lines_done;
    logic                          r_end_req,     n_end_req;
    logic                          r_end_op,      n_end_op;

    logic                          in_acc;
    logic                          push_en;
    logic                          pop_en;
    logic [PTR_W-1:0]              push_pos;
    logic [SUM_W-1:0]              pos_sum;
    logic [CSUM_W-1:0]             cred_sum;
    logic [CSUM_W-1:0]             room_sum;
    logic [cpvr_pkg::PASSES_W-1:0] last_pass;
    logic [cpvr_pkg::WORD_W-1:0]   ram_rdata;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign pos_sum  = SUM_W'(r_head) + SUM_W'(r_count);
    assign push_pos = (pos_sum >= SUM_W'(QUEUE_DEPTH))
                    ? PTR_W'(pos_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(pos_sum);

    assign last_pass = (r_total_passes == '0) ? '0 : r_total_passes - 1'b1;

    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_credits    = r_credits;
        n_lines      = r_lines;
        n_next_addr  = r_next_addr;
        n_cur_row    = r_cur_row;
        n_pass_count = r_pass_count;
        n_need       = r_need;
        n_empty      = r_empty;
        n_read_valid = 1'b0;
        n_read_addr  = '0;
        n_data_valid = 1'b0;
        n_row_index  = '0;
        n_error      = cpvr_pkg::ERR_NONE;
        push_en      = 1'b0;
        pop_en       = 1'b0;
        cred_sum     = '0;
        room_sum     = '0;

        unique case (i_command)
            cpvr_pkg::CMD_REQUEST: begin
                if (r_need && (r_lines != r_total_lines)) begin
                    n_read_valid = 1'b1;
                    n_read_addr  = r_next_addr;
                    cred_sum     = CSUM_W'(r_credits) + CSUM_W'(r_words_per_line);
                    n_credits    = cred_sum[cpvr_pkg::CRED_W]
                                 ? cpvr_pkg::CREDIT_MAX : cred_sum[cpvr_pkg::CRED_W-1:0];
                    n_lines      = r_lines + 1'b1;
                    room_sum     = CSUM_W'(n_credits) + CSUM_W'(r_words_per_line);
                    if ((room_sum > CSUM_W'(QUEUE_DEPTH)) || (n_lines == r_total_lines)) begin
                        n_need = 1'b0;
                    end
                    n_next_addr  = r_next_addr + cpvr_pkg::ADDR_W'(r_line_bytes);
                end
            end
            cpvr_pkg::CMD_RECEIVE: begin
                if (!(i_first_of_line && (i_data_word == '0))) begin
                    if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                        n_error = cpvr_pkg::ERR_FULL;
                    end else begin
                        push_en = 1'b1;
                        n_count = r_count + 1'b1;
                        n_empty = 1'b0;
                    end
                end
            end
            cpvr_pkg::CMD_POP: begin
                if (r_count == '0) begin
                    n_error = cpvr_pkg::ERR_EMPTY;
                end else begin
                    pop_en       = 1'b1;
                    n_data_valid = 1'b1;
                    n_row_index  = r_cur_row;
                    n_head       = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count      = r_count - 1'b1;
                    n_credits    = (r_credits != '0) ? r_credits - 1'b1 : r_credits;
                    if (n_count == '0) begin
                        n_empty = 1'b1;
                    end
                    room_sum     = CSUM_W'(n_credits) + CSUM_W'(r_words_per_line);
                    if ((r_lines < r_total_lines) && (room_sum < CSUM_W'(QUEUE_DEPTH))) begin
                        n_need = 1'b1;
                    end
                    n_cur_row    = (r_cur_row == r_row_last) ? r_row_first : r_cur_row + 1'b1;
                end
            end
            cpvr_pkg::CMD_RESTART: begin
                n_lines     = '0;
                n_cur_row   = r_row_first;
                n_next_addr = r_base_address;
                if (r_pass_count < cpvr_pkg::PASS_MAX) begin
                    n_pass_count = r_pass_count + 1'b1;
                end
            end
            cpvr_pkg::CMD_STOP: begin
                n_need = 1'b0;
            end
            default: begin
            end
        endcase

        n_lines_done = (n_lines == r_total_lines);
        n_end_req    = n_lines_done && (cpvr_pkg::PASSES_W'(n_pass_count) < last_pass);
        n_end_op     = n_lines_done && (cpvr_pkg::PASSES_W'(n_pass_count) == last_pass);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address   <= cpvr_pkg::RST_BASE_ADDRESS;
            r_line_bytes     <= cpvr_pkg::RST_LINE_BYTES;
            r_words_per_line <= cpvr_pkg::RST_WORDS_PER_LINE;
            r_total_lines    <= cpvr_pkg::RST_TOTAL_LINES;
            r_total_passes   <= cpvr_pkg::RST_TOTAL_PASSES;
            r_row_first      <= cpvr_pkg::RST_ROW_FIRST;
            r_row_last       <= cpvr_pkg::RST_ROW_LAST;
            r_head           <= '0;
            r_count          <= '0;
            r_credits        <= '0;
            r_lines          <= '0;
            r_next_addr      <= cpvr_pkg::RST_BASE_ADDRESS;
            r_cur_row        <= cpvr_pkg::RST_ROW_FIRST;
            r_pass_count     <= '0;
            r_need           <= 1'b1;
            r_empty          <= 1'b1;
            r_out_valid      <= 1'b0;
        end else begin
            if (in_acc) begin
                r_head       <= n_head;
                r_count      <= n_count;
                r_credits    <= n_credits;
                r_lines      <= n_lines;
                r_next_addr  <= n_next_addr;
                r_cur_row    <= n_cur_row;
                r_pass_count <= n_pass_count;
                r_need       <= n_need;
                r_empty      <= n_empty;
                r_out_valid  <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    cpvr_pkg::CFG_BASE_ADDRESS: begin
                        r_base_address <= i_cfg_wdata[cpvr_pkg::ADDR_W-1:0];
                        r_next_addr    <= i_cfg_wdata[cpvr_pkg::ADDR_W-1:0];
                    end
                    cpvr_pkg::CFG_LINE_BYTES:
                        r_line_bytes <= i_cfg_wdata[cpvr_pkg::LBYTES_W-1:0];
                    cpvr_pkg::CFG_WORDS_PER_LINE:
                        r_words_per_line <= i_cfg_wdata[cpvr_pkg::WPL_W-1:0];
                    cpvr_pkg::CFG_TOTAL_LINES:
                        r_total_lines <= i_cfg_wdata[cpvr_pkg::LINES_W-1:0];
                    cpvr_pkg::CFG_TOTAL_PASSES:
                        r_total_passes <= i_cfg_wdata[cpvr_pkg::PASSES_W-1:0];
                    cpvr_pkg::CFG_ROW_FIRST: begin
                        r_row_first <= i_cfg_wdata[cpvr_pkg::ROW_W-1:0];
                        r_cur_row   <= i_cfg_wdata[cpvr_pkg::ROW_W-1:0];
                    end
                    cpvr_pkg::CFG_ROW_LAST:
                        r_row_last <= i_cfg_wdata[cpvr_pkg::ROW_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_read_valid <= n_read_valid;
            r_read_addr  <= n_read_addr;
            r_data_valid <= n_data_valid;
            r_row_index  <= n_row_index;
            r_error      <= n_error;
            r_lines_done <= n_lines_done;
            r_end_req    <= n_end_req;
            r_end_op     <= n_end_op;
        end
    end

    cpvr_ram #(
        .WIDTH (cpvr_pkg::WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_word_queue (
        .i_clk   (i_clk),
        .i_we    (in_acc && push_en),
        .i_waddr (push_pos),
        .i_wdata (i_data_word),
        .i_re    (in_acc && pop_en),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid           = r_out_valid;
    assign o_read_valid          = r_read_valid;
    assign o_read_address        = r_read_addr;
    assign o_data_valid          = r_data_valid;
    assign o_data_word_out       = r_data_valid ? ram_rdata : '0;
    assign o_row_index           = r_row_index;
    assign o_request_needed      = r_need;
    assign o_queue_empty         = r_empty;
    assign o_all_lines_requested = r_lines_done;
    assign o_end_request         = r_end_req;
    assign o_end_operation       = r_end_op;
    assign o_error               = r_error;

    a_empty_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty == (r_count == '0))
        else $error("empty flag disagrees with queue count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_command == cpvr_pkg::CMD_POP) && (r_count != '0))
        |=> (r_count == $past(r_count) - 1'b1) && o_data_valid)
        else $error("pop beat did not take a word");

    a_pop_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_data_valid) |-> (o_error == cpvr_pkg::ERR_NONE) && !o_read_valid)
        else $error("popped word reported with error or read");

    a_stall_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result beat dropped");

endmodule

[rtl/core/cpvr_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module cpvr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
